/* rtl/vvp_pkg.sv */
// ----------------------------------------------------------------------------
// vvp_pkg: shared definitions for the velocity variance predictability unit
// Field widths, register indexes, reset values, and the exp(-x/64) score ROM.
// ----------------------------------------------------------------------------
package vvp_pkg;

    // Default window depth
    localparam int HISTORY_DEPTH_DEF = 16;

    // Field widths
    localparam int TIME_W      = 32;
    localparam int VEL_W       = 16;
    localparam int AXES        = 3;
    localparam int SAMPLE_W    = AXES * VEL_W;
    localparam int INTERVAL_W  = 16;
    localparam int SCALE_W     = 24;
    localparam int SCORE_W     = 16;
    localparam int VAR_W       = 34;
    localparam int X_W         = 10;
    localparam int SCALE_SHIFT = 6;

    // Configuration port
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_SCALE  = 2'd1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [SCALE_W-1:0]    SCALE_RESET    = 24'd250000;

    // Score mapping
    localparam int                  MIN_SAMPLES   = 3;
    localparam logic [SCORE_W-1:0]  DEFAULT_SCORE = 16'd22938;   // 0.7 in Q1.15
    localparam int                  ROM_DEPTH     = 1 << X_W;
    localparam logic [X_W-1:0]      X_MAX         = {X_W{1'b1}};
    localparam logic [VAR_W-1:0]    VAR_MAX       = {VAR_W{1'b1}};

    localparam logic [63:0] ONE_Q63  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] HALF_LSB = 64'h0000_8000_0000_0000;

    typedef logic [ROM_DEPTH-1:0][SCORE_W-1:0] score_rom_t;

    // (a*b) >> 63, low 64 bits
    function automatic logic [63:0] mul_q63(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = a * b;
        return prod[126:63];
    endfunction

    // exp(-1/64) in Q63 from its alternating series, truncating each term
    function automatic logic [63:0] exp_step_q63();
        logic [63:0] term;
        logic [63:0] r;
        term = ONE_Q63;
        r    = ONE_Q63;
        for (int k = 1; k < 20; k++)
        begin
            term = term >> 6;
            case (k)
                2:  term = term / 2;
                3:  term = term / 3;
                4:  term = term / 4;
                5:  term = term / 5;
                6:  term = term / 6;
                7:  term = term / 7;
                8:  term = term / 8;
                9:  term = term / 9;
                10: term = term / 10;
                11: term = term / 11;
                12: term = term / 12;
                13: term = term / 13;
                14: term = term / 14;
                15: term = term / 15;
                16: term = term / 16;
                17: term = term / 17;
                18: term = term / 18;
                19: term = term / 19;
                default: term = term;
            endcase
            if (k % 2 == 1)
                r = r - term;
            else
                r = r + term;
        end
        return r;
    endfunction

    // round(32768 * exp(-x/64)) for every x
    function automatic score_rom_t build_score_rom();
        score_rom_t  rom;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] rounded;
        p = ONE_Q63;
        r = exp_step_q63();
        for (int x = 0; x < ROM_DEPTH; x++)
        begin
            rounded = p + HALF_LSB;
            rom[x]  = rounded[63:48];
            p       = mul_q63(p, r);
        end
        return rom;
    endfunction

    localparam score_rom_t SCORE_ROM = build_score_rom();

endpackage

/* rtl/vvp_ram.sv */
// ----------------------------------------------------------------------------
// vvp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vvp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vvp_div.sv */
// ----------------------------------------------------------------------------
// vvp_div: bit-serial unsigned divider
// Restoring shift-subtract division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vvp_div #(
    parameter int DVD_W = 42,
    parameter int DVS_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    // Shift in the next dividend bit and try the subtract
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/velocity_variance_predictability_unit.sv */
// ----------------------------------------------------------------------------
// velocity_variance_predictability_unit: node predictability from velocity
// Stores velocity samples in a ring window and maps their variance to a score.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per report: now_ms and
//   vel_x/y/z. Output channel (out_valid/out_ready) returns one word per input:
//   score, variance, enough_samples, sample_taken. Registers are to be written over
//   cfg_wr_en/cfg_index/cfg_data while the block is idle, a rule the block does not enforce.
//   With fewer than three samples stored, an accepted word goes straight to the
//   last step. Otherwise the single multiplier takes one window read and one step
//   per axis for each stored sample, then the bit-serial divider makes two full
//   passes, its dividend 42 bits wide at the default depth of 16.
//   One word is in work at a time; in_ready is high only between words, so a
//   new word is taken only once the last one has reached the output register.
//   A finished word sits in the output register; the next input word is taken
//   while it waits, and a new result holds in the last step until out_ready.
//   Reset empties the window, clears the timer state, and restores the
//   register defaults (interval 1000 ms, scale 250000); no clearing pass.
// ----------------------------------------------------------------------------
module velocity_variance_predictability_unit #(
    parameter int HISTORY_DEPTH = vvp_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic [vvp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vvp_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [vvp_pkg::TIME_W-1:0]      now_ms,
    input  logic signed [vvp_pkg::VEL_W-1:0] vel_x,
    input  logic signed [vvp_pkg::VEL_W-1:0] vel_y,
    input  logic signed [vvp_pkg::VEL_W-1:0] vel_z,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [vvp_pkg::SCORE_W-1:0]     score,
    output logic [vvp_pkg::VAR_W-1:0]       variance,
    output logic                            enough_samples,
    output logic                            sample_taken
);

    import vvp_pkg::*;

    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = VEL_W + IDX_W;
    localparam int SQ_W    = 2 * VEL_W - 1 + IDX_W;
    localparam int NUM_W   = SQ_W + CNT_W + 2;
    localparam int PROD_W  = SQ_W + SUM_W;
    localparam int NN_W    = 2 * CNT_W;
    localparam int DVD_W   = (NUM_W > VAR_W + SCALE_SHIFT) ? NUM_W : VAR_W + SCALE_SHIFT;

    localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NN,
        S_READ,
        S_MAC,
        S_NQ,
        S_SS,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_ROM,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic [SCALE_W-1:0]    scale_reg, scale_next;

    // Window bookkeeping
    logic [IDX_W-1:0]  write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              have_reg, have_next;

    // Working registers
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [1:0]              axis_reg, axis_next;
    logic signed [SUM_W-1:0] sum_acc_reg [AXES];
    logic signed [SUM_W-1:0] sum_acc_next [AXES];
    logic [SQ_W-1:0]         sq_acc_reg [AXES];
    logic [SQ_W-1:0]         sq_acc_next [AXES];
    logic [NN_W-1:0]         nn_reg, nn_next;
    logic [NUM_W-1:0]        term_reg, term_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic [SCORE_W-1:0]      res_score_reg, res_score_next;
    logic [VAR_W-1:0]        res_var_reg, res_var_next;
    logic                    res_enough_reg, res_enough_next;
    logic                    res_taken_reg, res_taken_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [VAR_W-1:0]   out_var_reg, out_var_next;
    logic               out_enough_reg, out_enough_next;
    logic               out_taken_reg, out_taken_next;

    // Shared multiplier
    logic [SQ_W-1:0]   mul_a;
    logic [SUM_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    // Memory and divider hookup
    logic                ram_we;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic [SCALE_W-1:0]  div_divisor;
    logic [DVD_W-1:0]    div_quotient;
    logic                div_done;

    // Decoded values
    logic [TIME_W-1:0]       elapsed;
    logic                    take;
    logic [CNT_W-1:0]        count_inc;
    logic [CNT_W-1:0]        count_new;
    logic signed [VEL_W-1:0] vel_sel;
    logic [VEL_W-1:0]        vel_abs;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]        sum_abs;
    logic                    last_idx;

    // Decide whether this word's velocity enters the window
    assign elapsed   = now_ms - last_time_reg;
    assign take      = !have_reg || (elapsed >= TIME_W'(interval_reg));
    assign count_inc = (count_reg != CNT_W'(HISTORY_DEPTH)) ? count_reg + CNT_W'(1)
                                                            : count_reg;
    assign count_new = take ? count_inc : count_reg;
    assign ram_wdata = {vel_z, vel_y, vel_x};

    // Select the current axis of the sample word and of the sums
    assign vel_sel  = signed'(ram_rdata[VEL_W*axis_reg +: VEL_W]);
    assign vel_abs  = vel_sel[VEL_W-1] ? VEL_W'(-vel_sel) : VEL_W'(vel_sel);
    assign sum_sel  = sum_acc_reg[axis_reg];
    assign sum_abs  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign last_idx = (CNT_W'(idx_reg) + CNT_W'(1) == count_reg);

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next      = state_reg;
        interval_next   = interval_reg;
        scale_next      = scale_reg;
        write_slot_next = write_slot_reg;
        count_next      = count_reg;
        last_time_next  = last_time_reg;
        have_next       = have_reg;
        idx_next        = idx_reg;
        axis_next       = axis_reg;
        sum_acc_next    = sum_acc_reg;
        sq_acc_next     = sq_acc_reg;
        nn_next         = nn_reg;
        term_next       = term_reg;
        num_next        = num_reg;
        x_next          = x_reg;
        res_score_next  = res_score_reg;
        res_var_next    = res_var_reg;
        res_enough_next = res_enough_reg;
        res_taken_next  = res_taken_reg;
        out_valid_next  = out_valid_reg;
        out_score_next  = out_score_reg;
        out_var_next    = out_var_reg;
        out_enough_next = out_enough_reg;
        out_taken_next  = out_taken_reg;
        mul_a           = '0;
        mul_b           = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        div_start       = 1'b0;
        div_dividend    = DVD_W'(res_var_reg) << SCALE_SHIFT;
        div_divisor     = scale_reg;

        // Register writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SAMPLE_INTERVAL: interval_next = cfg_data[INTERVAL_W-1:0];
                REG_VARIANCE_SCALE:  scale_next    = cfg_data[SCALE_W-1:0];
                default:             ;
            endcase
        end

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_taken_next = take;
                    if (take)
                    begin
                        ram_we          = 1'b1;
                        write_slot_next = (write_slot_reg == IDX_W'(HISTORY_DEPTH - 1))
                                          ? '0 : write_slot_reg + IDX_W'(1);
                        count_next      = count_inc;
                        last_time_next  = now_ms;
                        have_next       = 1'b1;
                    end
                    if (count_new >= CNT_W'(MIN_SAMPLES))
                    begin
                        idx_next  = '0;
                        axis_next = '0;
                        num_next  = '0;
                        for (int a = 0; a < AXES; a++)
                        begin
                            sum_acc_next[a] = '0;
                            sq_acc_next[a]  = '0;
                        end
                        state_next = S_NN;
                    end
                    else
                    begin
                        res_score_next  = DEFAULT_SCORE;
                        res_var_next    = '0;
                        res_enough_next = 1'b0;
                        state_next      = S_FIN;
                    end
                end
            end

            // n squared for the variance divide
            S_NN:
            begin
                mul_a      = SQ_W'(count_reg);
                mul_b      = SUM_W'(count_reg);
                nn_next    = prod[NN_W-1:0];
                state_next = S_READ;
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_MAC;
            end

            // Accumulate sum and sum of squares, one axis per cycle
            S_MAC:
            begin
                mul_a = SQ_W'(vel_abs);
                mul_b = SUM_W'(vel_abs);
                sum_acc_next[axis_reg] = sum_acc_reg[axis_reg] + SUM_W'(vel_sel);
                sq_acc_next[axis_reg]  = sq_acc_reg[axis_reg] + prod[SQ_W-1:0];
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next = '0;
                    if (last_idx)
                        state_next = S_NQ;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
                else
                    axis_next = axis_reg + 2'd1;
            end

            // n * sum of squares
            S_NQ:
            begin
                mul_a      = sq_acc_reg[axis_reg];
                mul_b      = SUM_W'(count_reg);
                term_next  = prod[NUM_W-1:0];
                state_next = S_SS;
            end

            // Subtract sum squared and add into the numerator
            S_SS:
            begin
                mul_a    = SQ_W'(sum_abs);
                mul_b    = sum_abs;
                num_next = num_reg + term_reg - prod[NUM_W-1:0];
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = S_DIV1_GO;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_NQ;
                end
            end

            S_DIV1_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(num_reg);
                div_divisor  = SCALE_W'(nn_reg);
                state_next   = S_DIV1_WAIT;
            end

            // Saturate the variance
            S_DIV1_WAIT:
            begin
                if (div_done)
                begin
                    res_var_next = (|div_quotient[DVD_W-1:VAR_W]) ? VAR_MAX
                                                                  : div_quotient[VAR_W-1:0];
                    state_next   = S_DIV2_GO;
                end
            end

            S_DIV2_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV2_WAIT;
            end

            // Clamp the exponent index; a zero scale divides to all ones
            S_DIV2_WAIT:
            begin
                if (div_done)
                begin
                    x_next     = (|div_quotient[DVD_W-1:X_W]) ? X_MAX
                                                              : div_quotient[X_W-1:0];
                    state_next = S_ROM;
                end
            end

            S_ROM:
            begin
                res_score_next  = SCORE_ROM[x_reg];
                res_enough_next = 1'b1;
                state_next      = S_FIN;
            end

            // Hold until the output register is free
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_score_next  = res_score_reg;
                    out_var_next    = res_var_reg;
                    out_enough_next = res_enough_reg;
                    out_taken_next  = res_taken_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            interval_reg   <= INTERVAL_RESET;
            scale_reg      <= SCALE_RESET;
            write_slot_reg <= '0;
            count_reg      <= '0;
            last_time_reg  <= '0;
            have_reg       <= 1'b0;
            idx_reg        <= '0;
            axis_reg       <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                sum_acc_reg[a] <= '0;
                sq_acc_reg[a]  <= '0;
            end
            nn_reg         <= '0;
            term_reg       <= '0;
            num_reg        <= '0;
            x_reg          <= '0;
            res_score_reg  <= '0;
            res_var_reg    <= '0;
            res_enough_reg <= 1'b0;
            res_taken_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_score_reg  <= '0;
            out_var_reg    <= '0;
            out_enough_reg <= 1'b0;
            out_taken_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            interval_reg   <= interval_next;
            scale_reg      <= scale_next;
            write_slot_reg <= write_slot_next;
            count_reg      <= count_next;
            last_time_reg  <= last_time_next;
            have_reg       <= have_next;
            idx_reg        <= idx_next;
            axis_reg       <= axis_next;
            sum_acc_reg    <= sum_acc_next;
            sq_acc_reg     <= sq_acc_next;
            nn_reg         <= nn_next;
            term_reg       <= term_next;
            num_reg        <= num_next;
            x_reg          <= x_next;
            res_score_reg  <= res_score_next;
            res_var_reg    <= res_var_next;
            res_enough_reg <= res_enough_next;
            res_taken_reg  <= res_taken_next;
            out_valid_reg  <= out_valid_next;
            out_score_reg  <= out_score_next;
            out_var_reg    <= out_var_next;
            out_enough_reg <= out_enough_next;
            out_taken_reg  <= out_taken_next;
        end
    end

    // Sample window
    vvp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Shared divider for both divisions
    vvp_div #(
        .DVD_W (DVD_W),
        .DVS_W (SCALE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign score          = out_score_reg;
    assign variance       = out_var_reg;
    assign enough_samples = out_enough_reg;
    assign sample_taken   = out_taken_reg;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for velocity_variance_predictability_unit
// Drives timestamped velocity reports through the valid/ready input, keeps a
// scoring model of the sample window, and checks every output word against it
// or a fixed word from the plan, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int WINDOW_DEPTH    = vvp_pkg::HISTORY_DEPTH_DEF;
    localparam int VW              = vvp_pkg::VEL_W;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 1_200_000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int MAX_SHOWN       = 40;
    localparam longint VAR_LIMIT   = (longint'(1) << vvp_pkg::VAR_W) - 1;

    // spare register slots, ignored by the block
    localparam logic [vvp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [vvp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [vvp_pkg::SCORE_W-1:0] score;
        logic [vvp_pkg::VAR_W-1:0]   variance;
        logic                        enough;
        logic                        taken;
    } score_word_t;

    typedef enum logic {ROW_REPORT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [vvp_pkg::CFG_IDX_W-1:0]    reg_index;
        logic [vvp_pkg::CFG_DATA_W-1:0]   reg_data;
        logic [31:0]                      t;
        logic [15:0]                      vx;
        logic [15:0]                      vy;
        logic [15:0]                      vz;
        int                               reps;
        bit                               fixed_valid;
        score_word_t                      fixed;
    } plan_row_t;

    localparam score_word_t NO_FIXED = '0;

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [vvp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [vvp_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [vvp_pkg::TIME_W-1:0]        now_ms = '0;
    logic signed [VW-1:0]              vel_x = '0;
    logic signed [VW-1:0]              vel_y = '0;
    logic signed [VW-1:0]              vel_z = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [vvp_pkg::SCORE_W-1:0]       score;
    logic [vvp_pkg::VAR_W-1:0]         variance;
    logic                              enough_samples;
    logic                              sample_taken;

    velocity_variance_predictability_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .now_ms         (now_ms),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .vel_z          (vel_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .score          (score),
        .variance       (variance),
        .enough_samples (enough_samples),
        .sample_taken   (sample_taken)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scoring model state
    // ------------------------------------------------------------------------
    logic [vvp_pkg::SCORE_W-1:0]      score_table [vvp_pkg::ROM_DEPTH];
    logic [vvp_pkg::SAMPLE_W-1:0]     win_sample [WINDOW_DEPTH];
    int                               win_count = 0;
    int                               win_slot = 0;
    logic [31:0]                      last_stored_ms = '0;
    bit                               have_stored = 1'b0;
    logic [vvp_pkg::INTERVAL_W-1:0]   cur_interval = vvp_pkg::INTERVAL_RESET;
    logic [vvp_pkg::SCALE_W-1:0]      cur_scale = vvp_pkg::SCALE_RESET;

    score_word_t pending_scores [$];

    int error_count = 0;
    int reports_sent = 0;
    int samples_stored = 0;
    int scored_words = 0;
    int settings_written = 0;

    // build round(32768 * exp(-x/64)) by repeated Q63 multiplication
    initial
    begin : build_score_table
        logic [63:0]  term;
        logic [63:0]  decay;
        logic [63:0]  p;
        logic [63:0]  rounded;
        logic [127:0] prod;
        term  = 64'h8000_0000_0000_0000;
        decay = term;
        p     = term;
        for (int k = 1; k < 20; k++)
        begin
            term = term / (64 * k);
            if (k % 2 == 1)
                decay = decay - term;
            else
                decay = decay + term;
        end
        for (int x = 0; x < vvp_pkg::ROM_DEPTH; x++)
        begin
            rounded        = p + (64'd1 << 47);
            score_table[x] = rounded[63:48];
            prod           = p * decay;
            p              = prod[126:63];
        end
    end

    // store the sample if due, then score the window
    function automatic score_word_t predict_score(input logic [31:0] t,
                                                  input logic [15:0] vx,
                                                  input logic [15:0] vy,
                                                  input logic [15:0] vz);
        score_word_t r;
        longint      s;
        longint      q;
        longint      num;
        longint      n;
        longint      var_full;
        longint      xv;
        int          v;
        logic [31:0] elapsed;
        r.score    = vvp_pkg::DEFAULT_SCORE;
        r.variance = '0;
        r.enough   = 1'b0;
        r.taken    = 1'b0;
        elapsed    = t - last_stored_ms;
        if (!have_stored || elapsed >= cur_interval)
        begin
            win_sample[win_slot] = {vz, vy, vx};
            win_slot = (win_slot == WINDOW_DEPTH - 1) ? 0 : win_slot + 1;
            if (win_count < WINDOW_DEPTH)
                win_count++;
            last_stored_ms = t;
            have_stored    = 1'b1;
            r.taken        = 1'b1;
        end
        if (win_count >= vvp_pkg::MIN_SAMPLES)
        begin
            n   = win_count;
            num = 0;
            for (int a = 0; a < vvp_pkg::AXES; a++)
            begin
                s = 0;
                q = 0;
                for (int i = 0; i < win_count; i++)
                begin
                    v = $signed(win_sample[i][a*VW +: VW]);
                    s += v;
                    q += longint'(v) * v;
                end
                num += n * q - s * s;
            end
            var_full = num / (n * n);
            if (var_full > VAR_LIMIT)
                var_full = VAR_LIMIT;
            if (cur_scale == 0)
                xv = vvp_pkg::X_MAX;
            else
                xv = (var_full * 64) / longint'(cur_scale);
            if (xv > vvp_pkg::X_MAX)
                xv = vvp_pkg::X_MAX;
            r.score    = score_table[xv];
            r.variance = var_full[vvp_pkg::VAR_W-1:0];
            r.enough   = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // present one report and hold it until the block takes the word
    task automatic send_report(input logic [31:0] t, input logic [15:0] vx,
                               input logic [15:0] vy, input logic [15:0] vz,
                               input bit fixed_valid, input score_word_t fixed);
        score_word_t predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        now_ms   <= t;
        vel_x    <= vx;
        vel_y    <= vy;
        vel_z    <= vz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_score(t, vx, vy, vz);
        pending_scores.insert(pending_scores.size(), fixed_valid ? fixed : predicted);
        reports_sent++;
        samples_stored += predicted.taken;
        scored_words   += predicted.enough;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    // drop valid and hold until every expected word has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [vvp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vvp_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            vvp_pkg::REG_SAMPLE_INTERVAL: cur_interval = data[vvp_pkg::INTERVAL_W-1:0];
            vvp_pkg::REG_VARIANCE_SCALE:  cur_scale = data;
            default: ;
        endcase
        settings_written++;
    endtask

    // mostly near a center, sometimes a rail value or anything at all
    function automatic logic [15:0] pick_velocity(input logic [15:0] center,
                                                  input int amp);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h7FFF;
        if (r == 1)
            return 16'h8000;
        if (amp < 0)
            return 16'($urandom);
        return center + 16'($urandom_range(0, 2 * amp)) - 16'(amp);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: stall style is re-picked at random, its hold counted in cycles
    // ------------------------------------------------------------------------
    int ready_hold = 0;
    int stall_style = 0;
    int style_left = 300;

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
            case (stall_style)
                1: if ($urandom_range(0, 2) == 0) ready_hold = $urandom_range(1, 4);
                2: if ($urandom_range(0, 15) == 0) ready_hold = $urandom_range(10, 60);
                default: ;
            endcase
        end
        style_left--;
        if (style_left == 0)
        begin
            style_left  = $urandom_range(100, 500);
            stall_style = $urandom_range(0, 2);
        end
    end

    // ------------------------------------------------------------------------
    // Output check
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : check_port
        score_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scores.size() == 0)
            begin
                error_count++;
                $display("%0t: word with nothing expected: expected none, actual score %0d",
                         $time, score);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (score !== want.score)
                    report_mismatch("score", want.score, score);
                if (variance !== want.variance)
                    report_mismatch("variance", want.variance, variance);
                if (enough_samples !== want.enough)
                    report_mismatch("enough_samples", want.enough, enough_samples);
                if (sample_taken !== want.taken)
                    report_mismatch("sample_taken", want.taken, sample_taken);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed plan: reset state, rails, timer wrap, zero interval and scale,
    // a window of identical samples, masked and spare register writes
    // ------------------------------------------------------------------------
    plan_row_t directed_plan [22] = '{
        '{ROW_REPORT, 2'd0, 24'h0, 32'd0, 16'h0000, 16'h0000, 16'h0000, 1,
          1'b1, '{16'd22938, 34'd0, 1'b0, 1'b1}},
        '{ROW_REPORT, 2'd0, 24'h0, 32'd500, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1,
          1'b1, '{16'd22938, 34'd0, 1'b0, 1'b0}},
        '{ROW_REPORT, 2'd0, 24'h0, 32'd1000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1,
          1'b1, '{16'd22938, 34'd0, 1'b0, 1'b1}},
        '{ROW_REPORT, 2'd0, 24'h0, 32'd2000, 16'h8000, 16'h8000, 16'h8000, 1,
          1'b1, '{16'd0, 34'd2147418112, 1'b1, 1'b1}},
        '{ROW_REPORT, 2'd0, 24'h0, 32'd2999, 16'h0001, 16'h0002, 16'h0003, 1,
          1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'hFFFF_FF00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
          1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'h0000_02E7, 16'h0100, 16'hFF00, 16'h1234, 1,
          1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'h0000_02E8, 16'h7FFF, 16'h8000, 16'h0001, 1,
          1'b0, NO_FIXED},
        '{ROW_WRITE, REG_SPARE_2, 24'hFFFFFF, 32'd0, 16'h0, 16'h0, 16'h0, 1,
          1'b0, NO_FIXED},
        '{ROW_WRITE, REG_SPARE_3, 24'h000000, 32'd0, 16'h0, 16'h0, 16'h0, 1,
          1'b0, NO_FIXED},
        '{ROW_WRITE, vvp_pkg::REG_SAMPLE_INTERVAL, 24'hAB0000, 32'd0, 16'h0, 16'h0,
          16'h0, 1, 1'b0, NO_FIXED},
        '{ROW_WRITE, vvp_pkg::REG_VARIANCE_SCALE, 24'h000000, 32'd0, 16'h0, 16'h0,
          16'h0, 1, 1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'h0000_02E8, 16'h0064, 16'hFF9C, 16'h0005, 1,
          1'b0, NO_FIXED},
        '{ROW_WRITE, vvp_pkg::REG_VARIANCE_SCALE, 24'h000001, 32'd0, 16'h0, 16'h0,
          16'h0, 1, 1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'h0000_1000, 16'h04D2, 16'hEF1F, 16'h004D, 15,
          1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'h0000_1000, 16'h04D2, 16'hEF1F, 16'h004D, 1,
          1'b1, '{16'd32768, 34'd0, 1'b1, 1'b1}},
        '{ROW_WRITE, vvp_pkg::REG_SAMPLE_INTERVAL, 24'hFFFFFF, 32'd0, 16'h0, 16'h0,
          16'h0, 1, 1'b0, NO_FIXED},
        '{ROW_WRITE, vvp_pkg::REG_VARIANCE_SCALE, 24'hFFFFFF, 32'd0, 16'h0, 16'h0,
          16'h0, 1, 1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'h0000_1001, 16'h0000, 16'h0000, 16'h0000, 1,
          1'b0, NO_FIXED},
        '{ROW_REPORT, 2'd0, 24'h0, 32'h0001_0FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1,
          1'b0, NO_FIXED},
        '{ROW_WRITE, vvp_pkg::REG_SAMPLE_INTERVAL, 24'h0003E8, 32'd0, 16'h0, 16'h0,
          16'h0, 1, 1'b0, NO_FIXED},
        '{ROW_WRITE, vvp_pkg::REG_VARIANCE_SCALE, 24'h03D090, 32'd0, 16'h0, 16'h0,
          16'h0, 1, 1'b0, NO_FIXED}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int          interval;
        int          scale_pick;
        int          amp;
        int          burst_left;
        bit          gapless;
        logic [23:0] scale_val;
        logic [31:0] clock_ms;
        logic [31:0] delta;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;

        // hold reset, then release it on a falling edge
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed plan
        foreach (directed_plan[r])
        begin
            if (directed_plan[r].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(directed_plan[r].reg_index, directed_plan[r].reg_data);
            end
            else
            begin
                for (int k = 0; k < directed_plan[r].reps; k++)
                    send_report(directed_plan[r].t, directed_plan[r].vx,
                                directed_plan[r].vy, directed_plan[r].vz,
                                directed_plan[r].fixed_valid, directed_plan[r].fixed);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case ($urandom_range(0, 5))
                0:       interval = 0;
                1:       interval = 1;
                2:       interval = $urandom_range(2, 50);
                3:       interval = 1000;
                4:       interval = 16'hFFFF;
                default: interval = $urandom_range(0, 16'hFFFF);
            endcase
            scale_pick = $urandom_range(0, 9);
            case (scale_pick)
                0:       scale_val = 24'd0;
                1:       scale_val = 24'd1;
                2, 3:    scale_val = 24'($urandom_range(2, 1000));
                4:       scale_val = 24'd250000;
                5:       scale_val = 24'hFFFFFF;
                default: scale_val = 24'($urandom_range(1000, 2000000));
            endcase
            if (ph == 0)
            begin
                interval  = 0;
                scale_val = 24'd1;
            end
            else if (ph == PHASES - 1)
            begin
                interval  = 16'hFFFF;
                scale_val = 24'hFFFFFF;
            end
            write_reg(vvp_pkg::REG_SAMPLE_INTERVAL, {8'($urandom), 16'(interval)});
            write_reg(vvp_pkg::REG_VARIANCE_SCALE, scale_val);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 24'($urandom));

            clock_ms = $urandom;
            cx       = 16'($urandom);
            cy       = 16'($urandom);
            cz       = 16'($urandom);
            case ($urandom_range(0, 5))
                0:       amp = 0;
                1:       amp = 1;
                2:       amp = 12;
                3:       amp = 300;
                4:       amp = 3000;
                default: amp = -1;
            endcase
            gapless    = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 12);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // advance the clock around the interval, with rare long jumps
                case ($urandom_range(0, 9))
                    0:       delta = 0;
                    1:       delta = $urandom;
                    2:       delta = interval;
                    3:       delta = interval - 1;
                    default: delta = $urandom_range(0, 2 * interval + 2);
                endcase
                clock_ms += delta;
                send_report(clock_ms, pick_velocity(cx, amp), pick_velocity(cy, amp),
                            pick_velocity(cz, amp), 1'b0, NO_FIXED);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 39) == 0)
                        wait_drained();
                    else if (!gapless)
                        pause_sender($urandom_range(0, 9) == 0 ? $urandom_range(40, 180)
                                                               : $urandom_range(1, 30));
                end
            end
        end

        // let the last words out, then watch for strays
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("tb: %0d reports, %0d samples stored, %0d scored, %0d register writes",
                 reports_sent, samples_stored, scored_words, settings_written);
        $display("tb: %0d mismatches, %0d words still pending", error_count,
                 pending_scores.size());
        if (error_count == 0 && pending_scores.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // cycle budget
    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("tb: timeout after %0d cycles", CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

endmodule
